FILE: sv/mse_pkg.sv
// Shared types and codes for the multi-stack engine.
package mse_pkg;

  // Request codes carried on in_req_type
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  // Result status codes carried on out_status
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_t;

  localparam int SEL_W  = 2;
  localparam int WORD_W = 32;
  localparam int CFG_W  = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

endpackage

FILE: sv/mse_store.sv
// Shared word store: one write port, one read port, registered read data.
module mse_store #(
  parameter int WORDS  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [mse_pkg::WORD_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [mse_pkg::WORD_W-1:0]    rd_data
);

  logic [mse_pkg::WORD_W-1:0] mem_r [WORDS];
  logic [mse_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/mse_fill.sv
// Per-stack fill counters, cleared by reset.
module mse_fill #(
  parameter int NUM    = 4,
  parameter int IDX_W  = 2,
  parameter int FILL_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [FILL_W-1:0] rd_val,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [FILL_W-1:0] wr_val
);

  logic [FILL_W-1:0] fill_r [NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM; i++) begin
        fill_r[i] <= '0;
      end
    end else if (wr_en) begin
      fill_r[wr_idx] <= wr_val;
    end
  end

  assign rd_val = fill_r[rd_idx];

endmodule

FILE: sv/multi_stack_engine_unit.sv
// Top level of the multi-stack engine: control, fill counters and word store.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | req_type, stack_select, push_word
//   out_    | output    | out_valid/out_stall | read_word, status, empty_flag
//   cfg_    | input     | cfg_wr_en           | cfg_wr_data (stacks in use)
//
// Each request passes the idle state, which accepts it, reads the fill
// counter and issues the store access, then the load state, which loads the
// result register from the registered store read data. A result blocked by
// out_stall holds the unit in its load state. Reset is synchronous and
// clears fill counters, the sequencer and out_valid; the store itself is not cleared.
module multi_stack_engine_unit #(
  parameter int MAX_STACKS  = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mse_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [mse_pkg::SEL_W-1:0]          in_stack_select,
  input  logic signed [mse_pkg::WORD_W-1:0]  in_push_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mse_pkg::WORD_W-1:0]  out_read_word,
  output logic [1:0]                         out_status,
  output logic                               out_empty_flag
);

  // only stacks reachable through the select field get storage
  localparam int NUM_SEL = (MAX_STACKS < (1 << mse_pkg::SEL_W)) ?
                           MAX_STACKS : (1 << mse_pkg::SEL_W);
  localparam int IDX_W   = (NUM_SEL > 1) ? $clog2(NUM_SEL) : 1;
  localparam int WORDS   = NUM_SEL * STACK_DEPTH;
  localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);

  mse_pkg::state_t state_r, state_nxt;

  logic [mse_pkg::CFG_W-1:0]  cfg_stacks_r;
  logic                       accept;
  logic                       load;
  logic [IDX_W-1:0]           sel_idx;
  logic                       in_range;
  logic [FILL_W-1:0]          fill_cur;
  logic [FILL_W-1:0]          fill_dec;
  logic                       fill_zero;
  logic                       fill_full;
  logic [ADDR_W-1:0]          base_addr;
  logic                       fill_we;
  logic [FILL_W-1:0]          fill_wval;
  logic                       mem_we;
  logic                       mem_re;
  logic [mse_pkg::WORD_W-1:0] mem_rdata;
  mse_pkg::status_t           sts_calc;
  logic                       empty_calc;

  mse_pkg::status_t           pend_status_r;
  logic                       pend_empty_r;
  logic                       pend_rd_r;
  logic                       out_valid_r;
  logic [mse_pkg::WORD_W-1:0] out_word_r;
  mse_pkg::status_t           out_status_r;
  logic                       out_empty_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_stacks_r <= mse_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_stacks_r <= cfg_wr_data;
    end
  end

  assign accept  = in_valid && !in_stall;
  assign sel_idx = in_stack_select[IDX_W-1:0];
  assign in_range = ({1'b0, in_stack_select} < cfg_stacks_r) &&
                    (32'(in_stack_select) < 32'(MAX_STACKS));

  mse_fill #(
    .NUM    (NUM_SEL),
    .IDX_W  (IDX_W),
    .FILL_W (FILL_W)
  ) u_fill (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (sel_idx),
    .rd_val (fill_cur),
    .wr_en  (fill_we),
    .wr_idx (sel_idx),
    .wr_val (fill_wval)
  );

  assign fill_zero = (fill_cur == '0);
  assign fill_full = (fill_cur == FILL_W'(STACK_DEPTH));
  assign fill_dec  = fill_cur - FILL_W'(1);
  assign base_addr = ADDR_W'(32'(sel_idx) * STACK_DEPTH);

  // decode the request against the current fill
  always_comb begin
    sts_calc   = mse_pkg::STS_OK;
    empty_calc = 1'b0;
    fill_we    = 1'b0;
    fill_wval  = fill_cur;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (!in_range) begin
      sts_calc = mse_pkg::STS_RANGE;
    end else begin
      case (mse_pkg::req_t'(in_req_type))
        mse_pkg::REQ_PUSH: begin
          if (fill_full) begin
            sts_calc   = mse_pkg::STS_FULL;
            empty_calc = fill_zero;
          end else begin
            fill_we   = accept;
            fill_wval = fill_cur + FILL_W'(1);
            mem_we    = accept;
          end
        end
        mse_pkg::REQ_POP: begin
          if (fill_zero) begin
            sts_calc   = mse_pkg::STS_EMPTY;
            empty_calc = 1'b1;
          end else begin
            fill_we    = accept;
            fill_wval  = fill_dec;
            mem_re     = accept;
            empty_calc = (fill_dec == '0);
          end
        end
        mse_pkg::REQ_PEEK: begin
          if (fill_zero) begin
            sts_calc   = mse_pkg::STS_EMPTY;
            empty_calc = 1'b1;
          end else begin
            mem_re = accept;
          end
        end
        default: begin
          empty_calc = fill_zero;
        end
      endcase
    end
  end

  mse_store #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (base_addr + ADDR_W'(fill_cur)),
    .wr_data (in_push_word),
    .rd_en   (mem_re),
    .rd_addr (base_addr + ADDR_W'(fill_dec)),
    .rd_data (mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    load      = 1'b0;
    case (state_r)
      mse_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = mse_pkg::ST_LOAD;
        end
      end
      mse_pkg::ST_LOAD: begin
        // advance once the result register is free or being drained
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = mse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= sts_calc;
      pend_empty_r  <= empty_calc;
      pend_rd_r     <= mem_re;
    end
    if (load) begin
      out_word_r   <= pend_rd_r ? mem_rdata : '0;
      out_status_r <= pend_status_r;
      out_empty_r  <= pend_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_word  = $signed(out_word_r);
  assign out_status     = out_status_r;
  assign out_empty_flag = out_empty_r;

  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == mse_pkg::ST_LOAD)
    else $error("accepted request did not move to load");

  a_range_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mse_pkg::STS_RANGE |->
      !out_empty_flag && out_read_word == '0)
    else $error("range error result carries data");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mse_pkg::STS_EMPTY |-> out_empty_flag)
    else $error("empty status without empty flag");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_range |-> fill_cur <= FILL_W'(STACK_DEPTH))
    else $error("fill counter beyond stack depth");

endmodule

FILE: bench/tb_multi_stack_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_stack_engine_unit: request driver, stack predictor, monitor.
module tb_multi_stack_engine_unit;

  localparam int NUM_STACKS  = 4;
  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    mse_pkg::req_t                     kind;
    logic [mse_pkg::SEL_W-1:0]         sel;
    logic signed [mse_pkg::WORD_W-1:0] word;
  } stack_req_t;

  typedef struct {
    logic signed [mse_pkg::WORD_W-1:0] word;
    mse_pkg::status_t                  status;
    logic                              empty;
  } stack_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [mse_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [mse_pkg::SEL_W-1:0] in_stack_select = '0;
  logic signed [mse_pkg::WORD_W-1:0] in_push_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [mse_pkg::WORD_W-1:0] out_read_word;
  logic [1:0] out_status;
  logic out_empty_flag;

  multi_stack_engine_unit #(
    .MAX_STACKS (NUM_STACKS),
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_stack_select(in_stack_select),
    .in_push_word   (in_push_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_word  (out_read_word),
    .out_status     (out_status),
    .out_empty_flag (out_empty_flag)
  );

  always #10 clk = ~clk;

  stack_req_t pending_reqs[$];
  stack_rsp_t expected_results[$];
  stack_req_t cur_req;

  // predictor copy of the block state
  logic [mse_pkg::CFG_W-1:0]         model_in_use = mse_pkg::CFG_RESET;
  int                                model_fill [NUM_STACKS];
  logic signed [mse_pkg::WORD_W-1:0] model_words [NUM_STACKS][DEPTH];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_off = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int n_accepted = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_range = 0;

  function void stack_predict(input stack_req_t r);
    stack_rsp_t rsp;
    int f;
    rsp.word = '0;
    rsp.status = mse_pkg::STS_OK;
    rsp.empty = 1'b0;
    n_accepted++;
    if (int'(r.sel) >= int'(model_in_use) || int'(r.sel) >= NUM_STACKS) begin
      rsp.status = mse_pkg::STS_RANGE;
      n_range++;
    end else begin
      f = model_fill[r.sel];
      case (r.kind)
        mse_pkg::REQ_PUSH: begin
          if (f >= DEPTH) begin
            rsp.status = mse_pkg::STS_FULL;
            rsp.empty = (f == 0);
            n_full++;
          end else begin
            model_words[r.sel][f] = r.word;
            model_fill[r.sel] = f + 1;
          end
        end
        mse_pkg::REQ_POP: begin
          if (f == 0) begin
            rsp.status = mse_pkg::STS_EMPTY;
            rsp.empty = 1'b1;
            n_empty++;
          end else begin
            model_fill[r.sel] = f - 1;
            rsp.word = model_words[r.sel][f-1];
            rsp.empty = (f == 1);
          end
        end
        mse_pkg::REQ_PEEK: begin
          if (f == 0) begin
            rsp.status = mse_pkg::STS_EMPTY;
            rsp.empty = 1'b1;
            n_empty++;
          end else begin
            rsp.word = model_words[r.sel][f-1];
          end
        end
        default: begin
          rsp.empty = (f == 0);
        end
      endcase
    end
    expected_results.insert(expected_results.size(), rsp);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) stack_predict(cur_req);
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() != 0 && !hold_off &&
            $urandom_range(0, 99) >= snd_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.kind;
          in_stack_select <= cur_req.sel;
          in_push_word <= cur_req.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    stack_rsp_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no pending request: word %0d status %0d empty %0d",
                 out_read_word, out_status, out_empty_flag);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_read_word !== e.word) begin
            $error("read_word: expected %0d actual %0d", e.word, out_read_word);
            error_count++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            error_count++;
          end
          if (out_empty_flag !== e.empty) begin
            $error("empty_flag: expected %0d actual %0d", e.empty, out_empty_flag);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function void add_req(input mse_pkg::req_t kind, input int sel,
                        input logic signed [mse_pkg::WORD_W-1:0] word);
    stack_req_t r;
    r.kind = kind;
    r.sel = sel[mse_pkg::SEL_W-1:0];
    r.word = word;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function logic signed [mse_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // bursts on one stack lean to pushes or to pops; three tenths mix all kinds, a tenth also random stacks
  task automatic add_random(input int count, input logic [mse_pkg::CFG_W-1:0] cfg);
    int left, run, sel, pick, top;
    mse_pkg::req_t kind;
    left = count;
    top = (cfg == 0 || cfg > NUM_STACKS) ? NUM_STACKS - 1 : int'(cfg) - 1;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      sel = $urandom_range(0, top);
      run = $urandom_range(1, 20);
      if (run > left) run = left;
      for (int i = 0; i < run; i++) begin
        if (pick < 4) begin
          kind = ($urandom_range(0, 7) == 0) ? mse_pkg::REQ_PEEK : mse_pkg::REQ_PUSH;
        end else if (pick < 7) begin
          kind = ($urandom_range(0, 5) == 0) ? mse_pkg::REQ_QUERY : mse_pkg::REQ_POP;
        end else begin
          kind = mse_pkg::req_t'($urandom_range(0, 3));
        end
        if (pick == 9) sel = $urandom_range(0, NUM_STACKS - 1);
        add_req(kind, sel, rand_word());
      end
      left -= run;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_cfg(input logic [mse_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_in_use = value;
  endtask

  logic [mse_pkg::CFG_W-1:0] phase_cfg [NUM_PHASES] = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd4};
  int phase_len [NUM_PHASES] = '{110, 80, 110, 30, 100, 120};

  initial begin
    for (int s = 0; s < NUM_STACKS; s++) model_fill[s] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 31;
    rcv_idle_pct = 55;

    // directed: empty stack, word extremes, fill to full, range rejects
    add_req(mse_pkg::REQ_QUERY, 0, 32'sh1234_5678);
    add_req(mse_pkg::REQ_POP, 0, 32'sh0);
    add_req(mse_pkg::REQ_PEEK, 0, -32'sd1);
    add_req(mse_pkg::REQ_PUSH, 0, 32'sh8000_0000);
    add_req(mse_pkg::REQ_PEEK, 0, 32'sh0);
    add_req(mse_pkg::REQ_PUSH, 0, 32'sh7fff_ffff);
    add_req(mse_pkg::REQ_PUSH, 0, -32'sd1);
    add_req(mse_pkg::REQ_PUSH, 0, 32'sh0);
    for (int i = 0; i < DEPTH - 4; i++) add_req(mse_pkg::REQ_PUSH, 0, $urandom);
    add_req(mse_pkg::REQ_PUSH, 0, 32'sh5555_aaaa);
    add_req(mse_pkg::REQ_POP, 0, 32'sh0);
    add_req(mse_pkg::REQ_QUERY, 1, 32'sh0);
    add_req(mse_pkg::REQ_PUSH, 3, 32'sh7fff_ffff);
    add_req(mse_pkg::REQ_POP, 3, 32'sh0);
    add_req(mse_pkg::REQ_PEEK, 3, 32'sh0);
    add_req(mse_pkg::REQ_QUERY, 3, 32'sh0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      repeat (4) @(posedge clk);
      write_cfg(phase_cfg[p]);
      if (p < 2) begin
        snd_idle_pct = 31;
        rcv_idle_pct = 55;
      end else if (p < 4) begin
        snd_idle_pct = 55;
        rcv_idle_pct = 31;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      add_random(phase_len[p], phase_cfg[p]);
      if (p == 0) begin
        // hold the sender until every outstanding result is back
        while (pending_reqs.size() > phase_len[p] / 2) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Covered %0d requests across %0d stack-count settings, idle and stall mixes.",
             n_accepted, NUM_PHASES + 1);
    $display("Rejections seen: %0d full, %0d empty, %0d out of range.",
             n_full, n_empty, n_range);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
